@@ rtl/core/sorted_keyed_table_defines.svh @@
// ----------------------------------------------------------------------------
// sorted_keyed_table assertion macros
// Shared concurrent assertion forms, all disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEYED_TABLE_DEFINES_SVH
`define SORTED_KEYED_TABLE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define SKT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SKT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Types and codes shared by the sorted keyed table and its cells.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int YEAR_BITS   = 16;
   localparam int STATUS_BITS = 2;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // Broadcast to every cell in the row.
   typedef struct packed {
      logic                 insert;
      logic                 remove;
      logic [YEAR_BITS-1:0] key;
   } cell_ctrl_type;

endpackage

@@ rtl/core/sorted_keyed_table.sv @@
// ----------------------------------------------------------------------------
// sorted_keyed_table
// Bounded table of keyed entries held in ascending key order in a row of
// compare-and-shift cells.
// ----------------------------------------------------------------------------
// One operation is taken every cycle: busy stays low, and the result for an
// operation accepted at one edge is on the rsp_ ports for the single cycle
// that follows, marked by rsp_valid. The receiver cannot stall, so sample the
// result in that cycle. Latency is set by one compare-and-shift step in every
// cell plus the key-match OR across the row. Equal keys are stored newest
// first; remove deletes the first entry with the key. The head fields read
// zero when the table is empty.
module sorted_keyed_table #(
   parameter int CAPACITY     = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [skt_pkg::YEAR_BITS-1:0]        req_key_year,
   input  logic [PAYLOAD_BITS-1:0]              req_flow_value,
   output logic                                 rsp_valid,
   output logic [skt_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]        rsp_entry_count,
   output logic                                 rsp_head_valid,
   output logic [skt_pkg::YEAR_BITS-1:0]        rsp_head_year,
   output logic [PAYLOAD_BITS-1:0]              rsp_head_flow
);
   import skt_pkg::*;
   `include "sorted_keyed_table_defines.svh"

   localparam int CW = $clog2(CAPACITY+1);

   logic                    accept;
   logic                    full, found;
   cell_ctrl_type           ctrl;
   status_type              status_in, status_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff;

   logic [CAPACITY-1:0]     cell_lt, cell_match, cell_used;
   logic [YEAR_BITS-1:0]    cell_year [CAPACITY];
   logic [PAYLOAD_BITS-1:0] cell_flow [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(CAPACITY));
   assign found  = |cell_match;

   always_comb begin
      ctrl.key    = req_key_year;
      ctrl.insert = accept && (req_func == FUNC_INSERT) && !full;
      ctrl.remove = accept && (req_func == FUNC_REMOVE) && found;
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_DONE;
      if (req_func == FUNC_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else begin
         if (found) begin
            count_in = count_ff - CW'(1);
         end else begin
            status_in = STATUS_NOT_FOUND;
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic                    l_lt, l_used, r_used;
         logic [YEAR_BITS-1:0]    l_year, r_year;
         logic [PAYLOAD_BITS-1:0] l_flow, r_flow;

         if (g == 0) begin : g_first
            assign l_lt   = 1'b1;
            assign l_used = 1'b0;
            assign l_year = '0;
            assign l_flow = '0;
         end else begin : g_mid
            assign l_lt   = cell_lt[g-1];
            assign l_used = cell_used[g-1];
            assign l_year = cell_year[g-1];
            assign l_flow = cell_flow[g-1];
         end

         if (g == CAPACITY-1) begin : g_last
            assign r_used = 1'b0;
            assign r_year = '0;
            assign r_flow = '0;
         end else begin : g_inner
            assign r_used = cell_used[g+1];
            assign r_year = cell_year[g+1];
            assign r_flow = cell_flow[g+1];
         end

         skt_cell #(
            .PAYLOAD_BITS(PAYLOAD_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_flow   (req_flow_value),
            .left_lt    (l_lt),
            .left_used  (l_used),
            .left_year  (l_year),
            .left_flow  (l_flow),
            .right_used (r_used),
            .right_year (r_year),
            .right_flow (r_flow),
            .lt         (cell_lt[g]),
            .match      (cell_match[g]),
            .used       (cell_used[g]),
            .year       (cell_year[g]),
            .flow       (cell_flow[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // head comes straight from slot 0, which already holds the updated entry
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_head_valid  = cell_used[0];
   assign rsp_head_year   = cell_used[0] ? cell_year[0] : '0;
   assign rsp_head_flow   = cell_used[0] ? cell_flow[0] : '0;

   `SKT_ASSERT_NEXT(a_rsp_follows_transfer, clock, reset, accept, rsp_valid, "result missing after transfer")
   `SKT_ASSERT_ALWAYS(a_count_matches_cells, clock, reset, ($countones(cell_used) == int'(count_ff)), "entry count differs from used cells")
   `SKT_ASSERT_IMPL(a_full_status, clock, reset, (rsp_valid && (rsp_status == STATUS_FULL)), (rsp_entry_count == CW'(CAPACITY)), "full status with room left")
   `SKT_ASSERT_NEXT(a_found_shrinks, clock, reset, (ctrl.remove && !full), (count_ff == $past(count_ff) - CW'(1)), "remove did not drop an entry")

endmodule

@@ rtl/core/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: compares its key with the broadcast key and either holds,
// takes the new entry, takes its left neighbor (insert) or its right
// neighbor (remove).
// ----------------------------------------------------------------------------
module skt_cell #(
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  skt_pkg::cell_ctrl_type            ctrl,
   input  logic [PAYLOAD_BITS-1:0]           new_flow,
   input  logic                              left_lt,
   input  logic                              left_used,
   input  logic [skt_pkg::YEAR_BITS-1:0]     left_year,
   input  logic [PAYLOAD_BITS-1:0]           left_flow,
   input  logic                              right_used,
   input  logic [skt_pkg::YEAR_BITS-1:0]     right_year,
   input  logic [PAYLOAD_BITS-1:0]           right_flow,
   output logic                              lt,
   output logic                              match,
   output logic                              used,
   output logic [skt_pkg::YEAR_BITS-1:0]     year,
   output logic [PAYLOAD_BITS-1:0]           flow
);
   import skt_pkg::*;

   logic                    used_ff, used_in;
   logic [YEAR_BITS-1:0]    year_ff, year_in;
   logic [PAYLOAD_BITS-1:0] flow_ff, flow_in;

   assign lt    = used_ff && (year_ff < ctrl.key);
   assign match = used_ff && (year_ff == ctrl.key);

   always_comb begin
      used_in = used_ff;
      year_in = year_ff;
      flow_in = flow_ff;
      if (!lt) begin
         if (ctrl.insert) begin
            // first slot at or after the key takes the new entry, the rest shift up
            if (left_lt) begin
               used_in = 1'b1;
               year_in = ctrl.key;
               flow_in = new_flow;
            end else begin
               used_in = left_used;
               year_in = left_year;
               flow_in = left_flow;
            end
         end else if (ctrl.remove) begin
            used_in = right_used;
            year_in = right_year;
            flow_in = right_flow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      year_ff <= year_in;
      flow_ff <= flow_in;
   end

   assign used = used_ff;
   assign year = year_ff;
   assign flow = flow_ff;

endmodule

@@ tb/tb_sorted_keyed_table.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_keyed_table
// Self-checking bench for the sorted keyed table. A short table of directed
// operations exercises empty, extreme-key, equal-key and missing-key cases.
// Random inserts and removes follow, in phases that fill and drain the table
// so that it reaches both full and empty. Results are checked field by field
// against a typed reply or a software copy that tracks accepted transfers.
// ----------------------------------------------------------------------------
module tb_sorted_keyed_table;
   timeunit 1ns;
   timeprecision 1ps;

   import skt_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int PAYLOAD_BITS = 32;
   localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
   localparam int RANDOM_OPS   = 1950;
   localparam int DIRECTED_OPS = 19;

   typedef struct packed {
      status_type              status;
      logic [COUNT_BITS-1:0]   count;
      logic                    head_valid;
      logic [YEAR_BITS-1:0]    head_year;
      logic [PAYLOAD_BITS-1:0] head_flow;
   } table_reply_type;

   typedef struct {
      func_type                func;
      logic [YEAR_BITS-1:0]    key;
      logic [PAYLOAD_BITS-1:0] flow;
      bit                      typed;
      table_reply_type         reply;
   } table_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   func_type                req_func = FUNC_INSERT;
   logic [YEAR_BITS-1:0]    req_key_year = '0;
   logic [PAYLOAD_BITS-1:0] req_flow_value = '0;
   logic                    rsp_valid;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [COUNT_BITS-1:0]   rsp_entry_count;
   logic                    rsp_head_valid;
   logic [YEAR_BITS-1:0]    rsp_head_year;
   logic [PAYLOAD_BITS-1:0] rsp_head_flow;

   // Travels with each transfer: a typed-in reply replaces the prediction.
   bit                      row_typed = 1'b0;
   table_reply_type         row_reply = '0;

   // Software copy of the table, packed in slots 0 .. tbl_count-1.
   logic [YEAR_BITS-1:0]    tbl_year [CAPACITY];
   logic [PAYLOAD_BITS-1:0] tbl_flow [CAPACITY];
   int                      tbl_count = 0;

   table_reply_type         pending_replies [$];
   table_reply_type         predicted_reply;
   table_reply_type         expected_reply;
   table_row_type           dir_rows [DIRECTED_OPS];
   int                      idle_pct = 38;
   int                      fail_count = 0;

   sorted_keyed_table #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key_year    (req_key_year),
      .req_flow_value  (req_flow_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_head_valid  (rsp_head_valid),
      .rsp_head_year   (rsp_head_year),
      .rsp_head_flow   (rsp_head_flow)
   );

   always #5 clock = ~clock;

   // Apply one operation to the table copy and return the reply it yields.
   function automatic table_reply_type apply_table_op(func_type op,
                                                      logic [YEAR_BITS-1:0] key,
                                                      logic [PAYLOAD_BITS-1:0] flow);
      table_reply_type r;
      int              pos;
      int              i;
      r.status = STATUS_DONE;
      pos = 0;
      while (pos < tbl_count && tbl_year[pos] < key) pos++;
      if (op == FUNC_INSERT) begin
         if (tbl_count >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            for (i = tbl_count; i > pos; i--) begin
               tbl_year[i] = tbl_year[i-1];
               tbl_flow[i] = tbl_flow[i-1];
            end
            tbl_year[pos] = key;
            tbl_flow[pos] = flow;
            tbl_count++;
         end
      end else if (pos < tbl_count && tbl_year[pos] == key) begin
         for (i = pos; i + 1 < tbl_count; i++) begin
            tbl_year[i] = tbl_year[i+1];
            tbl_flow[i] = tbl_flow[i+1];
         end
         tbl_count--;
      end else begin
         r.status = STATUS_NOT_FOUND;
      end
      r.count      = COUNT_BITS'(tbl_count);
      r.head_valid = (tbl_count > 0);
      r.head_year  = (tbl_count > 0) ? tbl_year[0] : '0;
      r.head_flow  = (tbl_count > 0) ? tbl_flow[0] : '0;
      return r;
   endfunction

   // Offer one operation after a random gap and hold it until the transfer.
   task automatic send_op(func_type op, logic [YEAR_BITS-1:0] key,
                          logic [PAYLOAD_BITS-1:0] flow, bit typed,
                          table_reply_type reply);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_func       <= op;
      req_key_year   <= key;
      req_flow_value <= flow;
      row_typed      <= typed;
      row_reply      <= reply;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predicted_reply = apply_table_op(req_func, req_key_year, req_flow_value);
         pending_replies.push_back(row_typed ? row_reply : predicted_reply);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $error("result with no operation outstanding");
            fail_count++;
         end else begin
            expected_reply = pending_replies.pop_front();
            if (rsp_status !== expected_reply.status) begin
               $error("status: expected %0d, got %0d", expected_reply.status, rsp_status);
               fail_count++;
            end
            if (rsp_entry_count !== expected_reply.count) begin
               $error("entry_count: expected %0d, got %0d",
                      expected_reply.count, rsp_entry_count);
               fail_count++;
            end
            if (rsp_head_valid !== expected_reply.head_valid) begin
               $error("head_valid: expected %0d, got %0d",
                      expected_reply.head_valid, rsp_head_valid);
               fail_count++;
            end
            if (rsp_head_year !== expected_reply.head_year) begin
               $error("head_year: expected %0h, got %0h",
                      expected_reply.head_year, rsp_head_year);
               fail_count++;
            end
            if (rsp_head_flow !== expected_reply.head_flow) begin
               $error("head_flow: expected %0h, got %0h",
                      expected_reply.head_flow, rsp_head_flow);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      func_type                op;
      logic [YEAR_BITS-1:0]    key;
      logic [PAYLOAD_BITS-1:0] flow;
      int                      sel;
      int                      insert_pct;

      dir_rows[0]  = '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b1,
                       '{STATUS_NOT_FOUND, 7'd0, 1'b0, 16'h0000, 32'h0000_0000}};
      dir_rows[1]  = '{FUNC_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                       '{STATUS_NOT_FOUND, 7'd0, 1'b0, 16'h0000, 32'h0000_0000}};
      dir_rows[2]  = '{FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                       '{STATUS_DONE, 7'd1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF}};
      dir_rows[3]  = '{FUNC_INSERT, 16'h0000, 32'h0000_0000, 1'b1,
                       '{STATUS_DONE, 7'd2, 1'b1, 16'h0000, 32'h0000_0000}};
      // Equal key goes in front of the older entry.
      dir_rows[4]  = '{FUNC_INSERT, 16'h0000, 32'hA5A5_5A5A, 1'b1,
                       '{STATUS_DONE, 7'd3, 1'b1, 16'h0000, 32'hA5A5_5A5A}};
      dir_rows[5]  = '{FUNC_INSERT, 16'h8000, 32'h5A5A_A5A5, 1'b0, '0};
      dir_rows[6]  = '{FUNC_INSERT, 16'h7FFF, 32'h1234_5678, 1'b0, '0};
      dir_rows[7]  = '{FUNC_INSERT, 16'h8000, 32'hDEAD_BEEF, 1'b0, '0};
      dir_rows[8]  = '{FUNC_REMOVE, 16'h8000, 32'hFFFF_FFFF, 1'b0, '0};
      dir_rows[9]  = '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, '0};
      dir_rows[10] = '{FUNC_REMOVE, 16'h4000, 32'h0000_0000, 1'b0, '0};
      dir_rows[11] = '{FUNC_REMOVE, 16'hFFFF, 32'h0000_0000, 1'b0, '0};
      // Key above every stored key.
      dir_rows[12] = '{FUNC_REMOVE, 16'hFFFF, 32'h0000_0000, 1'b0, '0};
      dir_rows[13] = '{FUNC_INSERT, 16'h0001, 32'h0000_0001, 1'b0, '0};
      dir_rows[14] = '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, '0};
      dir_rows[15] = '{FUNC_REMOVE, 16'h0001, 32'h0000_0000, 1'b0, '0};
      dir_rows[16] = '{FUNC_REMOVE, 16'h7FFF, 32'h0000_0000, 1'b0, '0};
      dir_rows[17] = '{FUNC_REMOVE, 16'h8000, 32'h0000_0000, 1'b1,
                       '{STATUS_DONE, 7'd0, 1'b0, 16'h0000, 32'h0000_0000}};
      dir_rows[18] = '{FUNC_REMOVE, 16'h8000, 32'h0000_0000, 1'b1,
                       '{STATUS_NOT_FOUND, 7'd0, 1'b0, 16'h0000, 32'h0000_0000}};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_op(dir_rows[i].func, dir_rows[i].key, dir_rows[i].flow,
                 dir_rows[i].typed, dir_rows[i].reply);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         // Alternate fill and drain phases to reach full and empty.
         insert_pct = ((n / 150) % 2 == 0) ? 80 : 30;
         idle_pct   = (n >= 700 && n < 1000) ? 0 : 38;
         if (n == 1300) begin
            // Hold off until the table has answered everything.
            start <= 1'b0;
            @(posedge clock);
            while (pending_replies.size() != 0) @(posedge clock);
         end
         op  = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
         sel = $urandom_range(99);
         if (sel < 55 && tbl_count > 0)
            key = tbl_year[$urandom_range(tbl_count - 1)];
         else if (sel < 80)
            key = YEAR_BITS'($urandom_range(15));
         else
            key = YEAR_BITS'($urandom());
         flow = PAYLOAD_BITS'($urandom());
         send_op(op, key, flow, 1'b0, '0);
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
